// ----- design/kvls_pkg.sv -----
// kvls_pkg: shared types, character codes and defaults for the key/value line scanner.
// No dependencies; imported by every module of the block.
package kvls_pkg;

    // Fixed field widths
    localparam int CHAR_W    = 8;
    localparam int KEY_TXT_W = 64;
    localparam int KEY_LEN_W = 4;
    localparam int LEN_W     = 9;
    localparam int CFG_IDX_W = 1;

    // Parameter defaults
    localparam int KEY_MAX_DEF   = 8;
    localparam int MAX_VALUE_DEF = 256;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KEY_TEXT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 1'd1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Scanner phase, one-hot
    typedef enum logic [4:0] {
        PH_KEY        = 5'b00001,
        PH_WAIT_VALUE = 5'b00010,
        PH_SKIP_LINE  = 5'b00100,
        PH_IN_VALUE   = 5'b01000,
        PH_DONE       = 5'b10000
    } phase_t;

    // Key configuration as seen by the scanner (length already saturated)
    typedef struct packed {
        logic [KEY_TXT_W-1:0] text;
        logic [KEY_LEN_W-1:0] len;
    } key_cfg_t;

    // One result beat
    typedef struct packed {
        logic              byte_valid;
        logic [CHAR_W-1:0] value_byte;
        logic              is_end;
        logic              found;
        logic              truncated;
        logic [LEN_W-1:0]  value_length;
    } result_t;

    // Scanner status for checks at the top level
    typedef struct packed {
        phase_t phase;
        logic   count_zero;
    } scan_status_t;

endpackage

// ----- design/kvls_cfg_regs.sv -----
// kvls_cfg_regs: key text and key length registers behind the configuration port.
// Depends on kvls_pkg; saturates the key length to KEY_MAX for the scanner.
module kvls_cfg_regs
    import kvls_pkg::*;
#(
    parameter int KEY_MAX = KEY_MAX_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_TXT_W-1:0] cfg_data,
    output key_cfg_t             key_cfg
);

    logic [KEY_TXT_W-1:0] key_text_reg;
    logic [KEY_LEN_W-1:0] key_length_reg;
    logic [KEY_LEN_W-1:0] key_max_c;

    assign cfg_ready = 1'b1;
    assign key_max_c = KEY_LEN_W'(KEY_MAX);

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_text_reg   <= '0;
            key_length_reg <= KEY_LEN_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_KEY_TEXT:   key_text_reg   <= cfg_data;
                REG_KEY_LENGTH: key_length_reg <= cfg_data[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Lengths above KEY_MAX clamp; zero is passed through and never matches
    always_comb begin
        key_cfg.text = key_text_reg;
        key_cfg.len  = (key_length_reg > key_max_c) ? key_max_c : key_length_reg;
    end

endmodule

// ----- design/kvls_scan.sv -----
// kvls_scan: scanner state registers and the per-byte next-state and result logic.
// Depends on kvls_pkg; takes the key from kvls_cfg_regs, feeds kvls_out_stage.
module kvls_scan
    import kvls_pkg::*;
#(
    parameter int MAX_VALUE = MAX_VALUE_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [CHAR_W-1:0] char_byte,
    input  logic              end_of_stream,
    input  key_cfg_t          key_cfg,
    output logic              res_valid,
    output result_t           res,
    output scan_status_t      status
);

    localparam int VCNT_W = $clog2(MAX_VALUE + 1);

    phase_t                phase_reg, phase_next;
    logic [KEY_LEN_W-1:0]  kpos_reg, kpos_next;
    logic [VCNT_W-1:0]     vcnt_reg, vcnt_next;
    logic [VCNT_W-1:0]     cnt_inc;
    logic [CHAR_W-1:0]     key_byte;
    logic                  newline;
    logic                  blank;
    logic                  emit;

    assign newline  = char_byte inside {CH_CR, CH_LF};
    assign blank    = char_byte inside {CH_SPACE, CH_TAB};
    assign key_byte = key_cfg.text[{kpos_reg[2:0], 3'b000} +: CHAR_W];
    // first value byte restarts the count
    assign cnt_inc  = ((phase_reg == PH_WAIT_VALUE) ? '0 : vcnt_reg) + VCNT_W'(1);

    // Per-byte step
    always_comb begin
        phase_next = phase_reg;
        kpos_next  = kpos_reg;
        vcnt_next  = vcnt_reg;
        res_valid  = 1'b0;
        res        = '0;
        emit       = 1'b0;
        if (end_of_stream) begin
            if (phase_reg == PH_IN_VALUE) begin
                res_valid        = 1'b1;
                res.is_end       = 1'b1;
                res.found        = 1'b1;
                res.value_length = LEN_W'(vcnt_reg);
            end else if (phase_reg != PH_DONE) begin
                res_valid  = 1'b1;
                res.is_end = 1'b1;
            end
            phase_next = PH_KEY;
            kpos_next  = '0;
            vcnt_next  = '0;
        end else begin
            case (phase_reg)
                PH_KEY: begin
                    if (kpos_reg == '0 && (char_byte inside {CH_HASH, CH_SEMI})) begin
                        phase_next = PH_SKIP_LINE;
                    end else if (newline) begin
                        kpos_next = '0;
                    end else if (blank || char_byte == CH_EQ) begin
                        if (kpos_reg != '0)
                            phase_next = (kpos_reg == key_cfg.len) ? PH_WAIT_VALUE
                                                                   : PH_SKIP_LINE;
                    end else if (kpos_reg >= key_cfg.len || char_byte != key_byte) begin
                        phase_next = PH_SKIP_LINE;
                    end else begin
                        kpos_next = kpos_reg + KEY_LEN_W'(1);
                    end
                end
                PH_WAIT_VALUE: begin
                    if (newline) begin
                        kpos_next  = '0;
                        phase_next = PH_KEY;
                    end else if (!blank) begin
                        phase_next = PH_IN_VALUE;
                        emit       = 1'b1;
                    end
                end
                PH_SKIP_LINE: begin
                    if (newline) begin
                        kpos_next  = '0;
                        phase_next = PH_KEY;
                    end
                end
                PH_IN_VALUE: begin
                    if (newline || char_byte == CH_TAB) begin
                        phase_next       = PH_DONE;
                        res_valid        = 1'b1;
                        res.is_end       = 1'b1;
                        res.found        = 1'b1;
                        res.value_length = LEN_W'(vcnt_reg);
                    end else begin
                        emit = 1'b1;
                    end
                end
                default: ;
            endcase

            // Value byte out; the length limit ends the scan in the same beat
            if (emit) begin
                vcnt_next      = cnt_inc;
                res_valid      = 1'b1;
                res.byte_valid = 1'b1;
                res.value_byte = char_byte;
                if (cnt_inc >= VCNT_W'(MAX_VALUE)) begin
                    phase_next       = PH_DONE;
                    res.is_end       = 1'b1;
                    res.found        = 1'b1;
                    res.truncated    = 1'b1;
                    res.value_length = LEN_W'(cnt_inc);
                end
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_KEY;
            kpos_reg  <= '0;
            vcnt_reg  <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            kpos_reg  <= kpos_next;
            vcnt_reg  <= vcnt_next;
        end
    end

    assign status.phase      = phase_reg;
    assign status.count_zero = (vcnt_reg == '0);

endmodule

// ----- design/kvls_out_stage.sv -----
// kvls_out_stage: result register between the scanner and the m_ channel.
// Depends on kvls_pkg; holds a beat while the receiver stalls.
module kvls_out_stage
    import kvls_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    accept,
    input  logic    res_valid,
    input  result_t res,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg;

    // Take a new item whenever the held beat is gone or leaves this cycle
    assign s_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept)
            m_valid_next = res_valid;
        else if (m_ready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (accept && res_valid)
            m_res_reg <= res;
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

endmodule

// ----- design/key_value_line_scanner_top.sv -----
// key_value_line_scanner_top: top level of the key/value line scanner.
// Depends on kvls_pkg, kvls_cfg_regs, kvls_scan and kvls_out_stage.
//
// Usage:
//   s_ channel: one text byte per beat (s_char_byte), or an end-of-stream
//   beat (s_end_of_stream = 1, byte ignored) that closes the scan and
//   rearms the scanner for the next one.
//   m_ channel: zero or one result beat per input beat. A value byte comes
//   out with m_byte_valid; the last beat of a scan has m_is_end with
//   m_found, m_truncated and m_value_length.
//   cfg_ channel: index 0 writes the 64-bit key text (first char in bits
//   7..0), index 1 the key length; write only while the block is idle.
// Output: a result is registered and on m_ in the cycle after its input.
// Throughput: one byte per cycle unless m_ready stalls; the step logic
//   is a single pass between the scanner state and result registers.
// Reset: clears the scanner to key matching at line start, key text to 0,
//   key length to 1, and drops m_valid.
// Stall: when m_ready is low with a beat held, s_ready drops in the same
//   cycle; nothing is lost and the held beat stays unchanged.
module key_value_line_scanner_top
    import kvls_pkg::*;
#(
    parameter int KEY_MAX   = KEY_MAX_DEF,
    parameter int MAX_VALUE = MAX_VALUE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input bytes
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CHAR_W-1:0]    s_char_byte,
    input  logic                 s_end_of_stream,
    // results
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_byte_valid,
    output logic [CHAR_W-1:0]    m_value_byte,
    output logic                 m_is_end,
    output logic                 m_found,
    output logic                 m_truncated,
    output logic [LEN_W-1:0]     m_value_length,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_TXT_W-1:0] cfg_data
);

    key_cfg_t     key_cfg;
    result_t      res;
    result_t      m_res;
    scan_status_t status;
    logic         res_valid;
    logic         accept;

    assign accept = s_valid && s_ready;

    kvls_cfg_regs #(
        .KEY_MAX (KEY_MAX)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_cfg   (key_cfg)
    );

    kvls_scan #(
        .MAX_VALUE (MAX_VALUE)
    ) u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .char_byte     (s_char_byte),
        .end_of_stream (s_end_of_stream),
        .key_cfg       (key_cfg),
        .res_valid     (res_valid),
        .res           (res),
        .status        (status)
    );

    kvls_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .res_valid (res_valid),
        .res       (res),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_byte_valid   = m_res.byte_valid;
    assign m_value_byte   = m_res.value_byte;
    assign m_is_end       = m_res.is_end;
    assign m_found        = m_res.found;
    assign m_truncated    = m_res.truncated;
    assign m_value_length = m_res.value_length;

    // An end-of-stream beat always rearms the scanner
    a_eos_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_end_of_stream |=> status.phase == PH_KEY && status.count_zero)
        else $error("scanner not rearmed after end of stream");

    // A miss reports no length and no truncation
    a_miss_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_end && !m_found |-> m_value_length == '0 && !m_truncated
            && !m_byte_valid)
        else $error("end beat without a value carries data");

    // Truncation only on the last value byte of a found value
    a_trunc_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_truncated |-> m_is_end && m_found && m_byte_valid)
        else $error("truncation flag on a malformed beat");

    // A value byte can carry the end only when the limit was hit
    a_byte_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_valid && m_is_end |-> m_truncated)
        else $error("value byte ends the scan without truncation");

    // After the scan is done nothing gets past the scanner, not even end of stream
    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        status.phase == PH_DONE |-> !res_valid)
        else $error("result produced after the scan ended");

endmodule
